// File: design/crsd_pkg.sv
// Shared constants and command/status types for the route split block.
package crsd_pkg;

  localparam int DEPTH = 1024;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic start;      // latch inputs, update path sum
    logic mk_key;     // build candidate key
    logic rd_back;    // issue read of back entry
    logic pop_back;   // drop back entry
    logic push;       // write candidate
    logic add_w;      // update weight prefix
    logic rd_front;   // issue read of front entry
    logic pop_front;  // drop front entry
    logic finish;     // form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic back_ge;    // back entry key >= candidate
    logic front_over; // front window weight exceeds capacity
  } stat_t;

endpackage

// File: design/crsd_ctrl.sv
// Controller state machine for the route split block.
module crsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  crsd_pkg::stat_t   stat,
  output crsd_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_KEY   = 8'b0000_0010,
    S_BRD   = 8'b0000_0100,
    S_BCHK  = 8'b0000_1000,
    S_FRD   = 8'b0001_0000,
    S_FCHK  = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic take, give;

  assign in_stall  = (state != S_IDLE) && !(state == S_OUT && give);
  assign out_valid = (state == S_OUT);
  assign give = out_valid && !out_stall;
  assign take = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          cmd.start = 1'b1;
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        cmd.mk_key = 1'b1;
        state_next = S_BRD;
      end
      S_BRD: begin
        if (stat.empty) begin
          cmd.push = 1'b1;
          cmd.add_w = 1'b1;
          state_next = S_FRD;
        end else begin
          cmd.rd_back = 1'b1;
          state_next = S_BCHK;
        end
      end
      S_BCHK: begin
        if (stat.back_ge) begin
          cmd.pop_back = 1'b1;
          state_next = S_BRD;
        end else begin
          cmd.push = 1'b1;
          cmd.add_w = 1'b1;
          state_next = S_FRD;
        end
      end
      S_FRD: begin
        if (stat.empty) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_front = 1'b1;
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        if (stat.front_over) begin
          cmd.pop_front = 1'b1;
          state_next = S_FRD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (give) begin
          if (in_valid) begin
            cmd.start = 1'b1;
            state_next = S_KEY;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/crsd_dp.sv
// Datapath of the route split block: run state, deque memory, cost arithmetic.
module crsd_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  crsd_pkg::cmd_t       cmd,
  output crsd_pkg::stat_t      stat,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  logic signed [15:0]   pos_x,
  input  logic signed [15:0]   pos_y,
  input  logic [15:0]          item_weight,
  input  logic                 last,
  output logic [47:0]          total_cost,
  output logic                 error,
  output logic                 last_out
);

  localparam int AW = crsd_pkg::AW;
  localparam int CW = crsd_pkg::CW;

  logic [15:0] capacity;
  logic signed [15:0] cur_x, cur_y, prev_x, prev_y;
  logic [15:0] cur_w;
  logic cur_last;
  logic [47:0] path_sum, prev_best, key;
  logic [31:0] weight_prefix;
  logic [17:0] home;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic err;

  logic [47:0] mem_key [crsd_pkg::DEPTH];
  logic [31:0] mem_w   [crsd_pkg::DEPTH];
  logic [47:0] rd_key;
  logic [31:0] rd_w;

  function automatic logic [16:0] absd(input logic signed [15:0] a,
                                       input logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    return d[16] ? 17'(-d) : d;
  endfunction

  logic [18:0] step_d;
  logic [48:0] ps_sum, bh_sum, fin1;
  logic [48:0] fin_a;
  logic [47:0] fin_cost;
  logic [AW-1:0] back_slot, push_slot;
  logic [31:0] win;

  assign step_d = 19'(absd(pos_x, prev_x)) + 19'(absd(pos_y, prev_y));
  assign ps_sum = {1'b0, path_sum} + 49'(step_d);
  assign bh_sum = {1'b0, prev_best} + 49'(home);
  assign back_slot = head + AW'(count - CW'(1));
  assign push_slot = head + AW'(count);
  assign win = weight_prefix - rd_w;
  assign fin_a = {1'b0, rd_key} + {1'b0, path_sum};
  assign fin1 = (fin_a[48] ? {1'b0, crsd_pkg::MAX48} : fin_a) + 49'(home);
  assign fin_cost = fin1[48] ? crsd_pkg::MAX48 : fin1[47:0];

  assign stat.empty = (count == '0);
  assign stat.full = (count == CW'(crsd_pkg::DEPTH));
  assign stat.back_ge = (rd_key >= key);
  assign stat.front_over = (win > 32'(capacity));

  always_ff @(posedge clk) begin
    if (cmd.rd_back) begin
      rd_key <= mem_key[back_slot];
    end else if (cmd.rd_front) begin
      rd_key <= mem_key[head];
      rd_w <= mem_w[head];
    end
    if (cmd.push && !stat.full) begin
      mem_key[push_slot] <= key;
      mem_w[push_slot] <= weight_prefix;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_x <= pos_x;
      cur_y <= pos_y;
      cur_w <= item_weight;
      cur_last <= last;
      home <= 18'(absd(pos_x, 16'sd0)) + 18'(absd(pos_y, 16'sd0));
    end
    if (cmd.mk_key) begin
      key <= (bh_sum > {1'b0, path_sum}) ? 48'(bh_sum - {1'b0, path_sum}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 16'hFFFF;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      path_sum <= '0;
      weight_prefix <= '0;
      prev_best <= '0;
      head <= '0;
      count <= '0;
      err <= 1'b0;
      total_cost <= '0;
      error <= 1'b0;
      last_out <= 1'b0;
    end else begin
      if (cmd.start) begin
        path_sum <= ps_sum[48] ? crsd_pkg::MAX48 : ps_sum[47:0];
        err <= 1'b0;
      end
      if (cmd.pop_back) begin
        count <= count - CW'(1);
      end
      if (cmd.push) begin
        if (stat.full) begin
          err <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.add_w) begin
        weight_prefix <= weight_prefix + 32'(cur_w);
      end
      if (cmd.pop_front) begin
        head <= head + AW'(1);
        count <= count - CW'(1);
      end
      if (cmd.finish) begin
        last_out <= cur_last;
        if (count == '0) begin
          total_cost <= '0;
          error <= 1'b1;
        end else begin
          total_cost <= fin_cost;
          error <= err;
        end
        if (cur_last) begin
          // run end: back to the reset state, capacity kept
          prev_x <= '0;
          prev_y <= '0;
          path_sum <= '0;
          weight_prefix <= '0;
          prev_best <= '0;
          head <= '0;
          count <= '0;
        end else begin
          prev_x <= cur_x;
          prev_y <= cur_y;
          prev_best <= (count == '0) ? '0 : fin_cost;
        end
      end
    end
  end

endmodule

// File: design/capacitated_route_split_dp.sv
// Top level of the capacitated route split block.
// Capacitated route split: each transaction carries one point (pos_x, pos_y,
// item_weight, last) and yields one result transaction with the least total
// Manhattan distance of capacity-limited round trips from the origin that
// serve every point of the run so far. For each point the controller walks
// the candidate deque from the back, then from the front, with one
// registered memory read and one compare per entry, so the time from one
// acceptance to the next grows with the number of entries popped. A new
// point is accepted in the same cycle the previous result is taken; a
// stalled result holds off the next point. With last set, the run state
// clears after the result. The capacity register must be written through
// cfg_we/cfg_data only while the block is idle; the block itself does not
// enforce this. A point heavier than capacity gives error with total_cost 0;
// a full deque (1024 entries) drops the candidate and flags error.
module capacitated_route_split_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        item_weight,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [47:0]        total_cost,
  output logic               error,
  output logic               last_out
);

  crsd_pkg::cmd_t  cmd;
  crsd_pkg::stat_t stat;

  crsd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  crsd_dp u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_data, .pos_x, .pos_y,
    .item_weight, .last, .total_cost, .error, .last_out
  );

endmodule
